// ===== sv/wola_pkg.sv =====
package wola_pkg;

  localparam int unsigned DefMaxFftLen = 64;
  localparam int unsigned DefMaxFolds  = 8;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned DefCoeffBits = 16;

  localparam int unsigned CfgBits = 7;
  localparam int unsigned OutBits = 19;
  localparam int unsigned BinBits = 6;

  localparam logic [1:0] CFG_FFT_LEN = 2'd0;
  localparam logic [1:0] CFG_FOLDS   = 2'd1;
  localparam logic [1:0] CFG_OVERLAP = 2'd2;

  localparam logic [1:0] OVL_FULL  = 2'd0;
  localparam logic [1:0] OVL_3QTR  = 2'd1;
  localparam logic [1:0] OVL_HALF  = 2'd2;

  localparam logic KIND_COEFF  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

endpackage

// ===== sv/wola_mac.sv =====
module wola_mac import wola_pkg::*; #(
  parameter int unsigned SampleBits = DefSampleBits,
  parameter int unsigned CoeffBits  = DefCoeffBits,
  parameter int unsigned AccBits    = 48
) (
  input  logic                         clk_i,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic signed [CoeffBits-1:0]  coeff_i,
  input  logic signed [SampleBits-1:0] re_i,
  input  logic signed [SampleBits-1:0] im_i,
  output logic signed [OutBits-1:0]    re_o,
  output logic signed [OutBits-1:0]    im_o
);
  localparam int unsigned ProdBits = SampleBits + CoeffBits;
  localparam int unsigned Shift = CoeffBits - 1;

  logic signed [ProdBits-1:0] prod_re_q, prod_im_q;
  logic signed [AccBits-1:0]  acc_re_q, acc_im_q;
  logic                       en_q;

  always_ff @(posedge clk_i) begin
    en_q      <= en_i;
    prod_re_q <= coeff_i * re_i;
    prod_im_q <= coeff_i * im_i;
    if (clear_i) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (en_q) begin
      acc_re_q <= acc_re_q + AccBits'(prod_re_q);
      acc_im_q <= acc_im_q + AccBits'(prod_im_q);
    end
  end

  function automatic logic signed [OutBits-1:0] sat(input logic signed [AccBits-1:0] a);
    logic signed [AccBits-1:0] q;
    q = a >>> Shift;
    if (q > AccBits'(signed'((1 << (OutBits-1)) - 1))) sat = {1'b0, {(OutBits-1){1'b1}}};
    else if (q < -AccBits'(signed'(1 << (OutBits-1)))) sat = {1'b1, {(OutBits-1){1'b0}}};
    else sat = q[OutBits-1:0];
  endfunction

  assign re_o = sat(acc_re_q);
  assign im_o = sat(acc_im_q);
endmodule

// ===== sv/wola_channelizer_front_end.sv =====
// Folding front end of a WOLA polyphase filterbank.
// Input channel (in_valid_i/in_stall_o): kind 0 writes one window coefficient,
// kind 1 writes one complex sample into a ring of folds*fft_len entries.
// Once the ring is full, and after every hop of samples, one frame of fft_len
// bins leaves on the output channel (out_valid_o/out_stall_i), last on the
// final bin. Window and ring sit in two single-port-write memories; one
// shared complex multiplier walks the folds of each bin.
// A coefficient load or a sample that ends no frame does not stall the input.
// For each bin of a frame, both memories are read once per fold, then the
// products pass the multiply and accumulate stages and the bin is handed to
// the output register; the input opens once the last bin has left. Input is
// stalled while a frame is being computed.
// Reset clears the configuration to fft_len 64, folds 4, hop full, and empties
// the ring; memories are not cleared. A write to fft_len, folds or overlap restarts the fill.
// When the receiver stalls, the finished bin holds in the output register and
// the frame pauses until it is taken.
module wola_channelizer_front_end import wola_pkg::*; #(
  parameter int unsigned MaxFftLen  = DefMaxFftLen,
  parameter int unsigned MaxFolds   = DefMaxFolds,
  parameter int unsigned SampleBits = DefSampleBits,
  parameter int unsigned CoeffBits  = DefCoeffBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CfgBits-1:0]           cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [8:0]                   coeff_index_i,
  input  logic signed [CoeffBits-1:0]  coeff_value_i,
  input  logic signed [SampleBits-1:0] sample_re_i,
  input  logic signed [SampleBits-1:0] sample_im_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [BinBits-1:0]           bin_index_o,
  output logic signed [OutBits-1:0]    out_re_o,
  output logic signed [OutBits-1:0]    out_im_o,
  output logic                         last_o
);
  localparam int unsigned Depth  = MaxFftLen * MaxFolds;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned LW     = $clog2(MaxFftLen + 1);
  localparam int unsigned FW     = $clog2(MaxFolds + 1);
  localparam int unsigned CW     = $clog2(Depth + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [6:0] fft_len_q;
  logic [3:0] folds_q;
  logic [1:0] ovl_q;

  logic [LW-1:0] len;
  logic [FW-1:0] nf;
  logic [CW-1:0] w_len;
  logic [LW-1:0] hop;

  always_comb begin
    if (fft_len_q < 7'd2) len = LW'(2);
    else if (32'(fft_len_q) > MaxFftLen) len = LW'(MaxFftLen);
    else len = LW'(fft_len_q);
    if (folds_q == 4'd0) nf = FW'(1);
    else if (32'(folds_q) > MaxFolds) nf = FW'(MaxFolds);
    else nf = FW'(folds_q);
    w_len = CW'(len * nf);
    case (ovl_q)
      OVL_3QTR: hop = LW'((32'(len) * 3) >> 2);
      OVL_HALF: hop = LW'(len >> 1);
      default:  hop = len;
    endcase
  end

  logic [CoeffBits-1:0] wstore [Depth];
  logic [2*SampleBits-1:0] ring [Depth];
  logic signed [CoeffBits-1:0] w_rd_q;
  logic [2*SampleBits-1:0] r_rd_q;

  logic [1:0]    st_q;
  logic [AW-1:0] wpos_q;
  logic [CW-1:0] fill_q;
  logic [LW-1:0] hopc_q;
  logic [LW-1:0] k_q;
  logic [FW-1:0] f_q;
  logic [CW-1:0] idx_q;
  logic          rd_q;
  logic [1:0]    drain_q;

  logic in_acc, out_acc, cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_FFT_LEN || cfg_index_i == CFG_FOLDS
                                || cfg_index_i == CFG_OVERLAP);
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // load the finished bin once the output register is free
  logic out_load;
  assign out_load = !cfg_hit && (st_q == ST_RUN) && !(f_q < nf) && (drain_q == 2'd2)
                    && (!out_valid_o || out_acc);

  // read address: idx = f*len + k, ring slot wraps at w
  logic [CW:0] pos_sum;
  logic [AW-1:0] rpos;
  assign pos_sum = (CW+1)'(wpos_q) + (CW+1)'(idx_q);
  assign rpos = (pos_sum >= (CW+1)'(w_len)) ? AW'(pos_sum - (CW+1)'(w_len)) : AW'(pos_sum);

  logic rd_en;
  assign rd_en = (st_q == ST_RUN) && (f_q < nf);

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == KIND_COEFF && 32'(coeff_index_i) < Depth)
      wstore[AW'(coeff_index_i)] <= coeff_value_i;
    if (in_acc && kind_i == KIND_SAMPLE)
      ring[wpos_q] <= {sample_re_i, sample_im_i};
    w_rd_q <= wstore[idx_q[AW-1:0]];
    r_rd_q <= ring[rpos];
  end

  logic signed [OutBits-1:0] acc_re, acc_im;
  wola_mac #(.SampleBits(SampleBits), .CoeffBits(CoeffBits)) u_mac (
    .clk_i   (clk_i),
    .clear_i (st_q == ST_RUN && f_q == '0),
    .en_i    (rd_q),
    .coeff_i (w_rd_q),
    .re_i    (r_rd_q[2*SampleBits-1:SampleBits]),
    .im_i    (r_rd_q[SampleBits-1:0]),
    .re_o    (acc_re),
    .im_o    (acc_im)
  );

  logic [AW-1:0] wpos_inc;
  assign wpos_inc = (32'(wpos_q) + 1 >= 32'(w_len)) ? '0 : AW'(32'(wpos_q) + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_len_q <= 7'd64; folds_q <= 4'd4; ovl_q <= OVL_FULL;
      st_q <= ST_IDLE; wpos_q <= '0; fill_q <= '0; hopc_q <= '0;
      k_q <= '0; f_q <= '0; idx_q <= '0; rd_q <= 1'b0; drain_q <= '0;
      out_valid_o <= 1'b0; bin_index_o <= '0; out_re_o <= '0; out_im_o <= '0;
      last_o <= 1'b0;
    end else begin
      rd_q <= rd_en;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_acc) out_valid_o <= 1'b0;
      if (cfg_hit) begin
        case (cfg_index_i)
          CFG_FFT_LEN: fft_len_q <= cfg_data_i;
          CFG_FOLDS:   folds_q <= cfg_data_i[3:0];
          default:     ovl_q <= cfg_data_i[1:0];
        endcase
        wpos_q <= '0; fill_q <= '0; hopc_q <= '0;
      end else begin
        case (st_q)
          ST_IDLE: if (in_acc && kind_i == KIND_SAMPLE) begin
            logic go;
            go = 1'b0;
            wpos_q <= wpos_inc;
            if (fill_q < w_len) begin
              fill_q <= fill_q + 1'b1;
              if (fill_q + 1'b1 == w_len) go = 1'b1;
              hopc_q <= '0;
            end else if (hopc_q + 1'b1 >= hop) begin
              hopc_q <= '0; go = 1'b1;
            end else hopc_q <= hopc_q + 1'b1;
            if (go) begin
              st_q <= ST_RUN; k_q <= '0; f_q <= '0; idx_q <= '0;
            end
          end
          ST_RUN: begin
            if (f_q < nf) begin
              f_q <= f_q + 1'b1;
              idx_q <= idx_q + CW'(len);
              drain_q <= '0;
            end else if (drain_q != 2'd2) begin
              drain_q <= drain_q + 1'b1;
            end else if (out_load) begin
              bin_index_o <= BinBits'(k_q);
              out_re_o <= acc_re; out_im_o <= acc_im;
              last_o <= (k_q == len - 1'b1);
              if (k_q == len - 1'b1) st_q <= ST_OUT;
              else begin
                k_q <= k_q + 1'b1; f_q <= '0; idx_q <= CW'(k_q + 1'b1);
              end
            end
          end
          default: if (!out_valid_o || out_acc) st_q <= ST_IDLE;
        endcase
      end
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> in_stall_o) else $error("input open during frame");
  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (32'(bin_index_o) == 32'(len) - 1))
    else $error("last on wrong bin");
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= w_len || $past(cfg_hit)) else $error("fill overrun");
endmodule

// ===== tb/tb_wola_channelizer_front_end.sv =====
module tb_wola_channelizer_front_end;
  import wola_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned StoreDepth = DefMaxFftLen * DefMaxFolds;
  localparam int unsigned CoeffSpan = 16;
  localparam int unsigned MaxGap = 18;
  localparam longint CycleLimit = 3000000;
  localparam longint OutMax = 262143;
  localparam longint OutMin = -262144;

  typedef struct {
    logic                     kind;
    logic [8:0]               cidx;
    logic signed [15:0]       cval;
    logic signed [15:0]       re;
    logic signed [15:0]       im;
    int unsigned              gap;
  } request_t;

  typedef struct {
    logic [BinBits-1:0]        bin;
    logic signed [OutBits-1:0] re;
    logic signed [OutBits-1:0] im;
    logic                      last;
  } bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CfgBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = KIND_COEFF;
  logic [8:0] coeff_index_i = '0;
  logic signed [15:0] coeff_value_i = '0;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BinBits-1:0] bin_index_o;
  logic signed [OutBits-1:0] out_re_o;
  logic signed [OutBits-1:0] out_im_o;
  logic last_o;

  wola_channelizer_front_end u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .coeff_index_i, .coeff_value_i,
    .sample_re_i, .sample_im_i, .out_valid_o, .out_stall_i,
    .bin_index_o, .out_re_o, .out_im_o, .last_o
  );

  // folding model state
  logic signed [15:0] win_store [StoreDepth];
  logic signed [15:0] ring_re [StoreDepth];
  logic signed [15:0] ring_im [StoreDepth];
  logic [6:0] len_reg;
  logic [3:0] folds_reg;
  logic [1:0] ovl_reg;
  int unsigned wr_pos, fill_cnt, hop_cnt;

  request_t pending_q[$];
  request_t cur;
  bin_t bin_q[$];
  int unsigned idle_cnt;
  int unsigned stall_cnt;
  int unsigned errors;
  longint cycles;
  bit quiet;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned fold_len();
    if (len_reg < 2) return 2;
    if (len_reg > DefMaxFftLen) return DefMaxFftLen;
    return len_reg;
  endfunction

  function automatic int unsigned fold_count();
    if (folds_reg < 1) return 1;
    if (folds_reg > DefMaxFolds) return DefMaxFolds;
    return folds_reg;
  endfunction

  function automatic int unsigned hop_size(int unsigned len);
    if (ovl_reg == OVL_3QTR) return (len * 3) / 4;
    if (ovl_reg == OVL_HALF) return (len * 2) / 4;
    return len;
  endfunction

  function automatic logic signed [OutBits-1:0] scale_sat(longint acc);
    longint q;
    q = acc >>> 15;
    if (q > OutMax) q = OutMax;
    if (q < OutMin) q = OutMin;
    return q[OutBits-1:0];
  endfunction

  function automatic void fold_frame(int unsigned len, int unsigned nf);
    int unsigned w, idx, pos;
    longint acc_re, acc_im;
    bin_t b;
    w = len * nf;
    for (int unsigned k = 0; k < len; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int unsigned f = 0; f < nf; f++) begin
        idx = f * len + k;
        pos = wr_pos + idx;
        if (pos >= w) pos -= w;
        acc_re += longint'(win_store[idx]) * longint'(ring_re[pos]);
        acc_im += longint'(win_store[idx]) * longint'(ring_im[pos]);
      end
      b.bin = k[BinBits-1:0];
      b.re = scale_sat(acc_re);
      b.im = scale_sat(acc_im);
      b.last = (k == len - 1);
      bin_q.push_back(b);
    end
  endfunction

  function automatic void apply_request(request_t r);
    int unsigned len, nf, w;
    if (r.kind == KIND_COEFF) begin
      win_store[r.cidx] = r.cval;
      return;
    end
    len = fold_len();
    nf = fold_count();
    w = len * nf;
    if (wr_pos >= w) wr_pos = 0;
    ring_re[wr_pos] = r.re;
    ring_im[wr_pos] = r.im;
    wr_pos++;
    if (wr_pos >= w) wr_pos = 0;
    if (fill_cnt < w) begin
      fill_cnt++;
      if (fill_cnt == w) begin
        hop_cnt = 0;
        fold_frame(len, nf);
      end
      return;
    end
    hop_cnt++;
    if (hop_cnt >= hop_size(len)) begin
      hop_cnt = 0;
      fold_frame(len, nf);
    end
  endfunction

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic void add_coeff(int unsigned idx, logic signed [15:0] val);
    request_t r;
    r.kind = KIND_COEFF;
    r.cidx = idx[8:0];
    r.cval = val;
    r.re = 16'($urandom);
    r.im = 16'($urandom);
    r.gap = draw_gap();
    pending_q.push_back(r);
  endfunction

  function automatic void add_sample(logic signed [15:0] re, logic signed [15:0] im);
    request_t r;
    r.kind = KIND_SAMPLE;
    r.cidx = 9'($urandom);
    r.cval = 16'($urandom);
    r.re = re;
    r.im = im;
    r.gap = draw_gap();
    pending_q.push_back(r);
  endfunction

  // random samples with a coefficient reload now and then
  function automatic void add_stream(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) add_coeff($urandom_range(0, CoeffSpan - 1), 16'($urandom));
      add_sample(16'($urandom), 16'($urandom));
    end
  endfunction

  task automatic present(request_t r);
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    coeff_index_i <= r.cidx;
    coeff_value_i <= r.cval;
    sample_re_i <= r.re;
    sample_im_i <= r.im;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(cur);
        idle_cnt = 0;
        if (pending_q.size() > 0 && pending_q[0].gap == 0) begin
          cur = pending_q.pop_front();
          present(cur);
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_q.size() > 0) begin
        if (idle_cnt < pending_q[0].gap) begin
          idle_cnt++;
        end else begin
          cur = pending_q.pop_front();
          present(cur);
          idle_cnt = 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    bin_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bin_q.size() == 0) begin
          $display("%0t: unexpected bin %0d re %0d im %0d", $realtime, bin_index_o,
                   out_re_o, out_im_o);
          errors++;
        end else begin
          e = bin_q.pop_front();
          if (bin_index_o !== e.bin) begin
            $display("%0t: bin_index expected %0d actual %0d", $realtime, e.bin, bin_index_o);
            errors++;
          end
          if (out_re_o !== e.re) begin
            $display("%0t: out_re bin %0d expected %0d actual %0d", $realtime, e.bin, e.re,
                     out_re_o);
            errors++;
          end
          if (out_im_o !== e.im) begin
            $display("%0t: out_im bin %0d expected %0d actual %0d", $realtime, e.bin, e.im,
                     out_im_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last bin %0d expected %0b actual %0b", $realtime, e.bin, e.last,
                     last_o);
            errors++;
          end
        end
        stall_cnt = quiet ? 0 : $urandom_range(0, MaxGap);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      out_stall_i <= (stall_cnt != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("wola_channelizer_front_end test failed");
      $finish;
    end
  end

  // hold until every request is taken and every bin has come back
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || bin_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FFT_LEN: len_reg = val[6:0];
      CFG_FOLDS: folds_reg = val[3:0];
      CFG_OVERLAP: ovl_reg = val[1:0];
      default: return;
    endcase
    wr_pos = 0;
    fill_cnt = 0;
    hop_cnt = 0;
  endtask

  task automatic run_phase(int unsigned len, int unsigned nf, int unsigned ovl,
                           int unsigned hops);
    drain();
    write_cfg(CFG_FFT_LEN, CfgBits'(len));
    write_cfg(CFG_FOLDS, CfgBits'(nf));
    write_cfg(CFG_OVERLAP, CfgBits'(ovl));
    add_stream(fold_len() * fold_count() + hops * hop_size(fold_len()));
  endtask

  initial begin
    int unsigned len, nf;
    len_reg = 7'd64;
    folds_reg = 4'd4;
    ovl_reg = OVL_FULL;
    wr_pos = 0;
    fill_cnt = 0;
    hop_cnt = 0;
    errors = 0;
    cycles = 0;
    idle_cnt = 0;
    stall_cnt = 0;
    quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // keep every window within the loaded part of the store
    write_cfg(CFG_FFT_LEN, 7'd4);
    write_cfg(CFG_FOLDS, 7'd4);
    write_cfg(CFG_OVERLAP, CfgBits'(OVL_HALF));

    // load the used part of the store first so no frame reads an unloaded entry
    add_coeff(0, 16'sh8000);
    add_coeff(1, 16'sh7FFF);
    add_coeff(2, 16'sh0000);
    add_coeff(3, 16'shFFFF);
    for (int unsigned i = 4; i < CoeffSpan; i++) add_coeff(i, 16'($urandom));
    add_sample(16'sh8000, 16'sh7FFF);
    add_sample(16'sh7FFF, 16'sh8000);
    add_sample(16'sh0000, 16'shFFFF);
    add_sample(16'shFFFF, 16'sh0000);
    add_stream(12 + 2 * 2);

    // out-of-range index: no restart, stream continues
    drain();
    write_cfg(CFG_UNUSED, 7'h7F);
    add_stream(4);

    run_phase(0, 0, 3, 3);
    run_phase(2, 15, OVL_3QTR, 2);
    run_phase(8, 1, OVL_HALF, 2);
    run_phase(5, 3, OVL_3QTR, 2);

    // full-scale products across eight folds drive the sum into saturation
    drain();
    write_cfg(CFG_FFT_LEN, 7'd2);
    write_cfg(CFG_FOLDS, 7'd8);
    write_cfg(CFG_OVERLAP, CfgBits'(OVL_HALF));
    for (int unsigned i = 0; i < CoeffSpan; i++) add_coeff(i, 16'sh8000);
    for (int unsigned i = 0; i < CoeffSpan + 2; i++) add_sample(16'sh8000, 16'sh7FFF);

    for (int unsigned p = 0; p < 2; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(0, 4);
      nf = $urandom_range(0, 4);
      run_phase(len, nf, $urandom_range(0, 3), $urandom_range(2, 3));
    end
    quiet = 1'b0;

    drain();
    if (errors == 0) begin
      $display("wola_channelizer_front_end test passed");
    end else begin
      $display("wola_channelizer_front_end test failed");
    end
    $finish;
  end
endmodule
